/* hw/rtl/button_click_long_press_fsm_macros.svh */
// Assertion macros for the button click and long-press detector.
// Plain text macros, no package or module dependencies.
`ifndef BUTTON_CLICK_LONG_PRESS_FSM_MACROS_SVH
`define BUTTON_CLICK_LONG_PRESS_FSM_MACROS_SVH

`ifndef SYNTHESIS
`define BCLP_ASSERT_IMPLY(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("bclp: implication check failed");
`define BCLP_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("bclp: next-cycle check failed");
`else
`define BCLP_ASSERT_IMPLY(label, clk, rst, ante, cons)
`define BCLP_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif

`endif

/* hw/rtl/bclp_pkg.sv */
// Shared types and constants for the button click and long-press detector.
// No dependencies; used by bclp_core and button_click_long_press_fsm.
package bclp_pkg;

  localparam int unsigned CFG_IDX_W = 2;

  localparam logic [CFG_IDX_W-1:0] REG_ACTIVE_HIGH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CLICK_WINDOW = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_LONG_PRESS   = 2'd3;

  localparam logic        RST_ACTIVE_HIGH  = 1'b0;
  localparam logic [31:0] RST_DEBOUNCE     = 32'd50;
  localparam logic [31:0] RST_CLICK_WINDOW = 32'd300;
  localparam logic [31:0] RST_LONG_PRESS   = 32'd1000;

  typedef struct packed {
    logic        active_high;
    logic [31:0] debounce_ms;
    logic [31:0] click_window_ms;
    logic [31:0] long_press_ms;
  } cfg_t;

  typedef struct packed {
    logic [2:0] mode;
    logic [7:0] click_count;
    logic       clicked;
    logic       double_clicked;
    logic       triple_clicked;
    logic       press_event;
    logic       released_now;
    logic       long_press_event;
    logic       long_release_event;
  } res_t;

endpackage

/* hw/rtl/bclp_core.sv */
// Button state machine with its timers, click counter and result register.
// Depends on bclp_pkg for cfg_t and res_t.
module bclp_core (
  input  logic          clk,
  input  logic          rst,
  input  bclp_pkg::cfg_t cfg,
  input  logic          step,
  input  logic          level,
  input  logic [31:0]   now,
  output bclp_pkg::res_t res
);
  import bclp_pkg::*;

  typedef enum logic [2:0] {
    IDLE         = 3'd0,
    DEBOUNCING   = 3'd1,
    PRESSED      = 3'd2,
    CLICKED      = 3'd3,
    RELEASED     = 3'd4,
    LONG_HOLD    = 3'd5
  } mode_t;

  mode_t       mode;
  logic [31:0] debounce_start;
  logic [31:0] press_start;
  logic [31:0] click_start;
  logic [7:0]  clicks;

  mode_t       mode_next;
  logic [31:0] debounce_start_next;
  logic [31:0] press_start_next;
  logic [31:0] click_start_next;
  logic [7:0]  clicks_next;
  logic        moved;
  logic        pressed;
  logic [31:0] db_elapsed;
  logic [31:0] lp_elapsed;
  logic [31:0] cw_elapsed;
  res_t        res_next;

  always_comb begin
    pressed             = (level == cfg.active_high);
    db_elapsed          = now - debounce_start;
    lp_elapsed          = now - press_start;
    cw_elapsed          = now - click_start;
    mode_next           = mode;
    debounce_start_next = debounce_start;
    press_start_next    = press_start;
    click_start_next    = click_start;
    clicks_next         = clicks;
    moved               = 1'b0;

    unique case (mode)
      DEBOUNCING: begin
        if (db_elapsed > cfg.debounce_ms) begin
          moved = 1'b1;
          if (pressed) begin
            press_start_next = now;
            mode_next        = PRESSED;
          end else begin
            mode_next = IDLE;
          end
        end
      end
      PRESSED: begin
        if (!pressed) begin
          moved     = 1'b1;
          mode_next = CLICKED;
        end else if (lp_elapsed > cfg.long_press_ms) begin
          moved     = 1'b1;
          mode_next = LONG_HOLD;
        end
      end
      CLICKED: begin
        if (cw_elapsed < cfg.click_window_ms) begin
          if (clicks != 8'hFF) begin
            clicks_next = clicks + 8'd1;
          end
        end else begin
          clicks_next      = 8'd1;
          click_start_next = now;
        end
        moved     = 1'b1;
        mode_next = RELEASED;
      end
      RELEASED: begin
        moved     = 1'b1;
        mode_next = IDLE;
      end
      LONG_HOLD: begin
        if (!pressed) begin
          moved     = 1'b1;
          mode_next = RELEASED;
        end
      end
      default: begin
        if (pressed) begin
          moved               = 1'b1;
          debounce_start_next = now;
          mode_next           = DEBOUNCING;
        end
      end
    endcase

    res_next.mode               = mode_next;
    res_next.click_count        = clicks_next;
    res_next.clicked            = (mode_next == CLICKED) && (clicks_next == 8'd1);
    res_next.double_clicked     = (mode_next == CLICKED) && (clicks_next == 8'd2);
    res_next.triple_clicked     = (mode_next == CLICKED) && (clicks_next == 8'd3);
    res_next.press_event        = (mode_next == PRESSED) && moved;
    res_next.released_now       = (mode_next == RELEASED);
    res_next.long_press_event   = (mode_next == LONG_HOLD) && moved;
    res_next.long_release_event = (mode_next == RELEASED) && (mode == LONG_HOLD) && moved;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode           <= IDLE;
      debounce_start <= '0;
      press_start    <= '0;
      click_start    <= '0;
      clicks         <= '0;
      res            <= '0;
    end else if (step) begin
      mode           <= mode_next;
      debounce_start <= debounce_start_next;
      press_start    <= press_start_next;
      click_start    <= click_start_next;
      clicks         <= clicks_next;
      res            <= res_next;
    end
  end

endmodule

/* hw/rtl/button_click_long_press_fsm.sv */
// Top level of the button click and long-press detector: handshake, registers.
// Depends on bclp_pkg, bclp_core and button_click_long_press_fsm_macros.svh.
//
// Each item is one poll of the button pin with a millisecond timestamp and
// yields exactly one result item. The block takes one item per clock cycle
// sustained while out_ready is high; an item is held in the input register
// until the output can advance and then moves into the result register (one
// input register, one result register). The state machine, three wrapping
// 32-bit elapsed-time compares and the click counter all update in the
// single cycle in which the item moves from the input register to the result
// register.
// Registers sit on the APB port at byte addresses 0x0 active_high, 0x4
// debounce_ms, 0x8 click_window_ms and 0xC long_press_ms; write them only
// while no item is in flight.
`include "button_click_long_press_fsm_macros.svh"

module button_click_long_press_fsm (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        pin_level,
  input  logic [31:0] now_ms,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  mode,
  output logic [7:0]  click_count,
  output logic        clicked,
  output logic        double_clicked,
  output logic        triple_clicked,
  output logic        press_event,
  output logic        released_now,
  output logic        long_press_event,
  output logic        long_release_event
);
  import bclp_pkg::*;

  cfg_t                 cfg;
  logic [CFG_IDX_W-1:0] reg_idx;
  logic                 reg_wr;
  logic                 s1_valid;
  logic                 s1_level;
  logic [31:0]          s1_now;
  logic                 s1_adv;
  logic                 step;
  res_t                 res;

  assign pready  = 1'b1;
  assign reg_idx = paddr[3:2];
  assign reg_wr  = psel && penable && pwrite && pready;

  always_comb begin
    unique case (reg_idx)
      REG_ACTIVE_HIGH:  prdata = {31'd0, cfg.active_high};
      REG_DEBOUNCE:     prdata = cfg.debounce_ms;
      REG_CLICK_WINDOW: prdata = cfg.click_window_ms;
      REG_LONG_PRESS:   prdata = cfg.long_press_ms;
      default:          prdata = '0;
    endcase
  end

  assign s1_adv   = !out_valid || out_ready;
  assign step     = s1_valid && s1_adv;
  assign in_ready = !s1_valid || s1_adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.active_high     <= RST_ACTIVE_HIGH;
      cfg.debounce_ms     <= RST_DEBOUNCE;
      cfg.click_window_ms <= RST_CLICK_WINDOW;
      cfg.long_press_ms   <= RST_LONG_PRESS;
      s1_valid            <= 1'b0;
      out_valid           <= 1'b0;
    end else begin
      if (reg_wr) begin
        unique case (reg_idx)
          REG_ACTIVE_HIGH:  cfg.active_high     <= pwdata[0];
          REG_DEBOUNCE:     cfg.debounce_ms     <= pwdata;
          REG_CLICK_WINDOW: cfg.click_window_ms <= pwdata;
          REG_LONG_PRESS:   cfg.long_press_ms   <= pwdata;
          default:          cfg                 <= cfg;
        endcase
      end
      if (in_ready) begin
        s1_valid <= in_valid;
      end
      if (s1_adv) begin
        out_valid <= s1_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_level <= pin_level;
      s1_now   <= now_ms;
    end
  end

  bclp_core u_core (
    .clk   (clk),
    .rst   (rst),
    .cfg   (cfg),
    .step  (step),
    .level (s1_level),
    .now   (s1_now),
    .res   (res)
  );

  assign mode               = res.mode;
  assign click_count        = res.click_count;
  assign clicked            = res.clicked;
  assign double_clicked     = res.double_clicked;
  assign triple_clicked     = res.triple_clicked;
  assign press_event        = res.press_event;
  assign released_now       = res.released_now;
  assign long_press_event   = res.long_press_event;
  assign long_release_event = res.long_release_event;

  `BCLP_ASSERT_NEXT(a_hold_pending, clk, rst, s1_valid && !s1_adv, s1_valid)
  `BCLP_ASSERT_IMPLY(a_ready_when_empty, clk, rst, !out_valid, in_ready)
  `BCLP_ASSERT_IMPLY(a_long_release_flags, clk, rst, long_release_event, released_now && !press_event)

endmodule
